@@ rtl/core/triangle_tangent_bitangent_defines.svh @@
// Assertion helpers for the tangent-space block; all sample on clk_i and
// are off while rst_ni is low.
`ifndef TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH
`define TRIANGLE_TANGENT_BITANGENT_DEFINES_SVH

`define TTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication
`define TTB_ASSERT_IMPL(label, ante, cons, msg) \
  `TTB_ASSERT(label, (ante) |-> (cons), msg)

// Next-cycle implication
`define TTB_ASSERT_NEXT(label, ante, cons, msg) \
  `TTB_ASSERT(label, (ante) |=> (cons), msg)

`endif

@@ rtl/core/ttb_pkg.sv @@
`default_nettype none

package ttb_pkg;

  localparam int PosW   = 32;               // position, Q16.16
  localparam int TexW   = 24;               // texture coordinate, Q8.16
  localparam int ResW   = 32;               // result component, Q16.16
  localparam int SlotW  = 2;
  localparam int PosDW  = PosW + 1;         // position delta
  localparam int TexDW  = TexW + 1;         // texture delta
  localparam int ProdW  = PosDW + TexDW;    // one product
  localparam int NumW   = ProdW + 1;        // difference of two products
  localparam int DetW   = 2 * TexDW + 1;    // determinant, signed
  localparam int FracW  = 16;               // fraction bits of the quotient
  localparam int QW     = ResW - 1;         // quotient magnitude bits

  localparam logic [SlotW-1:0] SlotLast = 2'd2;
  localparam logic [ResW-1:0]  SatMax   = 32'h7FFF_FFFF;
  localparam logic [ResW-1:0]  SatMin   = 32'h8000_0000;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x;
    logic signed [PosW-1:0] pos_y;
    logic signed [PosW-1:0] pos_z;
    logic signed [TexW-1:0] tex_u;
    logic signed [TexW-1:0] tex_v;
  } in_word_t;

  typedef struct packed {
    logic signed [ResW-1:0] tangent_x;
    logic signed [ResW-1:0] tangent_y;
    logic signed [ResW-1:0] tangent_z;
    logic signed [ResW-1:0] bitangent_x;
    logic signed [ResW-1:0] bitangent_y;
    logic signed [ResW-1:0] bitangent_z;
    logic [SlotW-1:0]       vertex_slot;
    logic                   last;
    logic                   degenerate;
  } out_word_t;

endpackage

`default_nettype wire

@@ rtl/core/ttb_stream_if.sv @@
`default_nettype none

interface ttb_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/triangle_tangent_bitangent.sv @@
`default_nettype none

// Per-triangle tangent and bitangent from UVs. Vertices arrive one word each,
// three per triangle. The first two are stored and give no result. The third
// vertex starts the solve: one shared 33x25 multiplier forms the UV
// determinant, then each of the six components takes two products and a
// subtract, a range check and a restoring divider that retires one quotient
// bit per cycle; a component that saturates skips the divider, and a zero
// determinant skips the components. After the solve, three result words,
// slots 0 to 2 with last on slot 2, leave at one per cycle the sink accepts.
// No input is taken from the third vertex until the last result word has gone.
// A zero determinant gives zero vectors with degenerate set; a quotient out of
// range saturates to the Q16.16 limits.
module triangle_tangent_bitangent (
  input  logic         clk_i,
  input  logic         rst_ni,
  ttb_stream_if.sink   in_i,
  ttb_stream_if.source out_o
);

  localparam int CntW = $clog2(ttb_pkg::QW);
  localparam logic [2:0] CompDet  = 3'd0;
  localparam logic [2:0] CompTan  = 3'd1;
  localparam logic [2:0] CompBit  = 3'd4;
  localparam logic [2:0] CompLast = 3'd6;
  localparam logic [CntW-1:0] DivLast = CntW'(ttb_pkg::QW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_MUL2, S_SUB, S_DIVCHK, S_DIV, S_STORE, S_OUT
  } state_e;

  state_e                     state_q;
  logic [1:0]                 vcnt_q;
  logic [2:0]                 comp_q;
  logic [CntW-1:0]            cnt_q;
  logic [ttb_pkg::SlotW-1:0]  slot_q;

  // held vertex 0 and the deltas
  logic signed [ttb_pkg::PosW-1:0]  p0_q [3];
  logic signed [ttb_pkg::TexW-1:0]  u0_q, v0_q;
  logic signed [ttb_pkg::PosDW-1:0] dp1_q [3];
  logic signed [ttb_pkg::PosDW-1:0] dp2_q [3];
  logic signed [ttb_pkg::TexDW-1:0] du1_q, dv1_q, du2_q, dv2_q;

  logic signed [ttb_pkg::ProdW-1:0] prod_q, first_q;
  logic                             det_neg_q, neg_q, sat_q, degen_q;
  logic [ttb_pkg::DetW-1:0]         dmag_q;
  logic [ttb_pkg::NumW-1:0]         mag_q;
  logic [ttb_pkg::DetW-1:0]         rem_q, rem_d;
  logic [ttb_pkg::QW-1:0]           qr_q, qr_d;
  logic signed [ttb_pkg::ResW-1:0]  res_q [6];

  logic                             in_acc, out_acc, sec;
  logic [1:0]                       idx;
  logic signed [ttb_pkg::PosDW-1:0] op_a;
  logic signed [ttb_pkg::TexDW-1:0] op_b;
  logic signed [ttb_pkg::ProdW-1:0] prod;
  logic signed [ttb_pkg::NumW-1:0]  diff;
  logic                             diff_neg, num_neg;
  logic [ttb_pkg::NumW-1:0]         diff_mag;
  logic [ttb_pkg::DetW:0]           trial;
  logic                             trial_ge, sat;
  logic [ttb_pkg::ResW-1:0]         quot, comp_val;

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;
  assign sec     = (state_q == S_MUL2);

  // operand selection for the shared multiplier
  always_comb begin
    logic [2:0] off;
    off  = (comp_q >= CompBit) ? comp_q - CompBit : comp_q - CompTan;
    idx  = off[1:0];
    op_a = ttb_pkg::PosDW'(du1_q);
    op_b = dv2_q;
    if (comp_q == CompDet) begin
      op_a = sec ? ttb_pkg::PosDW'(dv1_q) : ttb_pkg::PosDW'(du1_q);
      op_b = sec ? du2_q : dv2_q;
    end else if (comp_q < CompBit) begin
      op_a = sec ? dp2_q[idx] : dp1_q[idx];
      op_b = sec ? dv1_q : dv2_q;
    end else begin
      op_a = sec ? dp1_q[idx] : dp2_q[idx];
      op_b = sec ? du2_q : du1_q;
    end
  end

  assign prod     = ttb_pkg::ProdW'(op_a) * ttb_pkg::ProdW'(op_b);
  assign diff     = ttb_pkg::NumW'(first_q) - ttb_pkg::NumW'(prod_q);
  assign diff_neg = diff[ttb_pkg::NumW-1];
  assign diff_mag = diff_neg ? ttb_pkg::NumW'(-diff) : ttb_pkg::NumW'(diff);
  assign num_neg  = diff_neg ^ det_neg_q;

  // quotient overflows 31 bits exactly when the dividend's top part reaches det
  assign sat = (mag_q >> (ttb_pkg::QW - ttb_pkg::FracW)) >= ttb_pkg::NumW'(dmag_q);

  // one restoring divide step
  assign trial    = {rem_q, qr_q[ttb_pkg::QW-1]};
  assign trial_ge = trial >= {1'b0, dmag_q};
  assign rem_d    = trial_ge ? ttb_pkg::DetW'(trial - {1'b0, dmag_q})
                             : trial[ttb_pkg::DetW-1:0];
  assign qr_d     = {qr_q[ttb_pkg::QW-2:0], trial_ge};

  assign quot     = {1'b0, qr_q};
  always_comb begin
    if (sat_q) comp_val = neg_q ? ttb_pkg::SatMin : ttb_pkg::SatMax;
    else       comp_val = neg_q ? -quot : quot;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q  <= 2'd0;
      comp_q  <= CompDet;
      cnt_q   <= '0;
      slot_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (vcnt_q)
              2'd1:    vcnt_q <= 2'd2;
              2'd2: begin
                vcnt_q  <= 2'd0;
                comp_q  <= CompDet;
                state_q <= S_MUL1;
              end
              default: vcnt_q <= 2'd1;
            endcase
          end
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_SUB;
        S_SUB: begin
          if (comp_q == CompDet && diff == '0) begin
            slot_q  <= '0;
            state_q <= S_OUT;
          end else if (comp_q == CompDet) begin
            comp_q  <= CompTan;
            state_q <= S_MUL1;
          end else begin
            state_q <= S_DIVCHK;
          end
        end
        S_DIVCHK: begin
          cnt_q   <= '0;
          state_q <= sat ? S_STORE : S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivLast) state_q <= S_STORE;
        end
        S_STORE: begin
          if (comp_q == CompLast) begin
            slot_q  <= '0;
            state_q <= S_OUT;
          end else begin
            comp_q  <= comp_q + 3'd1;
            state_q <= S_MUL1;
          end
        end
        S_OUT: begin
          if (out_acc) begin
            slot_q <= slot_q + 1'b1;
            if (slot_q == ttb_pkg::SlotLast) state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (vcnt_q)
        2'd1: begin
          dp1_q[0] <= ttb_pkg::PosDW'(in_i.data.pos_x) - ttb_pkg::PosDW'(p0_q[0]);
          dp1_q[1] <= ttb_pkg::PosDW'(in_i.data.pos_y) - ttb_pkg::PosDW'(p0_q[1]);
          dp1_q[2] <= ttb_pkg::PosDW'(in_i.data.pos_z) - ttb_pkg::PosDW'(p0_q[2]);
          du1_q    <= ttb_pkg::TexDW'(in_i.data.tex_u) - ttb_pkg::TexDW'(u0_q);
          dv1_q    <= ttb_pkg::TexDW'(in_i.data.tex_v) - ttb_pkg::TexDW'(v0_q);
        end
        2'd2: begin
          dp2_q[0] <= ttb_pkg::PosDW'(in_i.data.pos_x) - ttb_pkg::PosDW'(p0_q[0]);
          dp2_q[1] <= ttb_pkg::PosDW'(in_i.data.pos_y) - ttb_pkg::PosDW'(p0_q[1]);
          dp2_q[2] <= ttb_pkg::PosDW'(in_i.data.pos_z) - ttb_pkg::PosDW'(p0_q[2]);
          du2_q    <= ttb_pkg::TexDW'(in_i.data.tex_u) - ttb_pkg::TexDW'(u0_q);
          dv2_q    <= ttb_pkg::TexDW'(in_i.data.tex_v) - ttb_pkg::TexDW'(v0_q);
        end
        default: begin
          p0_q[0] <= in_i.data.pos_x;
          p0_q[1] <= in_i.data.pos_y;
          p0_q[2] <= in_i.data.pos_z;
          u0_q    <= in_i.data.tex_u;
          v0_q    <= in_i.data.tex_v;
        end
      endcase
    end

    if (state_q == S_MUL1 || state_q == S_MUL2) prod_q <= prod;
    if (state_q == S_MUL2) first_q <= prod_q;

    if (state_q == S_SUB) begin
      if (comp_q == CompDet) begin
        degen_q   <= (diff == '0);
        det_neg_q <= diff_neg;
        dmag_q    <= diff_mag[ttb_pkg::DetW-1:0];
        if (diff == '0) begin
          for (int k = 0; k < 6; k++) res_q[k] <= '0;
        end
      end else begin
        neg_q <= num_neg;
        mag_q <= diff_mag;
      end
    end

    if (state_q == S_DIVCHK) begin
      sat_q <= sat;
      rem_q <= ttb_pkg::DetW'(mag_q >> (ttb_pkg::QW - ttb_pkg::FracW));
      qr_q  <= {mag_q[ttb_pkg::QW-ttb_pkg::FracW-1:0], {ttb_pkg::FracW{1'b0}}};
    end

    if (state_q == S_DIV) begin
      rem_q <= rem_d;
      qr_q  <= qr_d;
    end

    if (state_q == S_STORE) res_q[comp_q - CompTan] <= comp_val;
  end

  assign in_i.ready              = (state_q == S_IDLE);
  assign out_o.valid             = (state_q == S_OUT);
  assign out_o.data.tangent_x    = res_q[0];
  assign out_o.data.tangent_y    = res_q[1];
  assign out_o.data.tangent_z    = res_q[2];
  assign out_o.data.bitangent_x  = res_q[3];
  assign out_o.data.bitangent_y  = res_q[4];
  assign out_o.data.bitangent_z  = res_q[5];
  assign out_o.data.vertex_slot  = slot_q;
  assign out_o.data.last         = (slot_q == ttb_pkg::SlotLast);
  assign out_o.data.degenerate   = degen_q;

endmodule

`default_nettype wire

@@ rtl/core/ttb_checker.sv @@
`default_nettype none

`include "triangle_tangent_bitangent_defines.svh"

module ttb_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input ttb_pkg::out_word_t out_data_i
);

  `TTB_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result word dropped while stalled")
  `TTB_ASSERT_IMPL(a_last_slot, out_valid_i, out_data_i.last == (out_data_i.vertex_slot == ttb_pkg::SlotLast), "last does not match the final slot")
  `TTB_ASSERT_IMPL(a_degen_zero, out_valid_i && out_data_i.degenerate, (out_data_i.tangent_x == '0) && (out_data_i.tangent_y == '0) && (out_data_i.tangent_z == '0) && (out_data_i.bitangent_x == '0) && (out_data_i.bitangent_y == '0) && (out_data_i.bitangent_z == '0), "degenerate word carries non-zero vectors")
  `TTB_ASSERT_NEXT(a_slot_step, out_valid_i && out_ready_i && !out_data_i.last, out_valid_i && (out_data_i.vertex_slot == $past(out_data_i.vertex_slot) + 2'd1), "slot did not advance to the next word")
  `TTB_ASSERT(a_no_overlap, !(in_ready_i && out_valid_i), "input taken while results are pending")

endmodule

bind triangle_tangent_bitangent ttb_checker u_ttb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire

@@ tb/sv/tb_triangle_tangent_bitangent.sv @@
`timescale 1ns / 100ps

module tb_triangle_tangent_bitangent;

  localparam int IdleLimit  = 4000;  // cycles without any handshake
  localparam int DrainWait  = 260;   // at least the longest solve plus the three result words
  localparam int LongHold   = 400;
  localparam int MaxReports = 100;

  localparam logic signed [95:0] QuotHi = 96'sd2147483647;
  localparam logic signed [95:0] QuotLo = -96'sd2147483648;

  localparam int PosMax = 32'sh7FFF_FFFF;
  localparam int PosMin = 32'sh8000_0000;
  localparam int TexMax = 8388607;
  localparam int TexMin = -8388608;
  localparam int One    = 65536;

  typedef enum int {TRI_MESH, TRI_DEGEN, TRI_TINY_UV, TRI_RAW} tri_kind_e;
  typedef enum int {SINK_OPEN, SINK_PATTERN, SINK_SPARSE} sink_mode_e;

  logic clk_i;
  logic rst_ni;

  ttb_stream_if #(.word_t(ttb_pkg::in_word_t))  in_if ();
  ttb_stream_if #(.word_t(ttb_pkg::out_word_t)) out_if ();

  triangle_tangent_bitangent dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // predictor state
  int     verts_held;
  longint held_xyz[2][3];
  longint held_uv[2][2];

  ttb_pkg::out_word_t frames_due[$];

  int n_vertices, n_triangles, n_degenerate, n_clipped, n_words_checked;
  int n_mismatches;

  // sender and receiver control
  bit gaps_on;
  int burst_left;
  int hold_req;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int signed_range(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic ttb_pkg::in_word_t make_word(int px, int py, int pz, int tu, int tv);
    ttb_pkg::in_word_t w;
    w.pos_x = px;
    w.pos_y = py;
    w.pos_z = pz;
    w.tex_u = tu[ttb_pkg::TexW-1:0];
    w.tex_v = tv[ttb_pkg::TexW-1:0];
    return w;
  endfunction

  // num * 2^16 / den, truncated toward zero, clipped to the Q16.16 range
  function automatic logic [ttb_pkg::ResW-1:0] fixed_quotient(input longint num,
                                                              input longint den,
                                                              output bit clipped);
    logic signed [95:0] wide_n, wide_d, wide_q;
    wide_n  = num;
    wide_n  = wide_n <<< ttb_pkg::FracW;
    wide_d  = den;
    wide_q  = wide_n / wide_d;
    clipped = 1'b0;
    if (wide_q > QuotHi) begin
      clipped = 1'b1;
      return ttb_pkg::SatMax;
    end
    if (wide_q < QuotLo) begin
      clipped = 1'b1;
      return ttb_pkg::SatMin;
    end
    return wide_q[ttb_pkg::ResW-1:0];
  endfunction

  task automatic solve_vertex(input ttb_pkg::in_word_t w);
    longint p[3], d1[3], d2[3];
    longint u, v, du1, dv1, du2, dv2, det;
    logic [ttb_pkg::ResW-1:0] tan_c[3], bitan_c[3];
    bit clip_t, clip_b, any_clip, degen;
    ttb_pkg::out_word_t f;
    p[0] = $signed(w.pos_x);
    p[1] = $signed(w.pos_y);
    p[2] = $signed(w.pos_z);
    u = $signed(w.tex_u);
    v = $signed(w.tex_v);
    n_vertices++;
    if (verts_held < 2) begin
      for (int i = 0; i < 3; i++) held_xyz[verts_held][i] = p[i];
      held_uv[verts_held][0] = u;
      held_uv[verts_held][1] = v;
      verts_held++;
      return;
    end
    verts_held = 0;
    n_triangles++;
    for (int i = 0; i < 3; i++) begin
      d1[i] = held_xyz[1][i] - held_xyz[0][i];
      d2[i] = p[i] - held_xyz[0][i];
    end
    du1 = held_uv[1][0] - held_uv[0][0];
    dv1 = held_uv[1][1] - held_uv[0][1];
    du2 = u - held_uv[0][0];
    dv2 = v - held_uv[0][1];
    det = du1 * dv2 - dv1 * du2;
    degen = (det == 0);
    any_clip = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (degen) begin
        tan_c[i]   = '0;
        bitan_c[i] = '0;
      end else begin
        tan_c[i]   = fixed_quotient(d1[i] * dv2 - d2[i] * dv1, det, clip_t);
        bitan_c[i] = fixed_quotient(d2[i] * du1 - d1[i] * du2, det, clip_b);
        any_clip   = any_clip | clip_t | clip_b;
      end
    end
    if (degen) n_degenerate++;
    if (any_clip) n_clipped++;
    for (int k = 0; k < 3; k++) begin
      f.tangent_x   = tan_c[0];
      f.tangent_y   = tan_c[1];
      f.tangent_z   = tan_c[2];
      f.bitangent_x = bitan_c[0];
      f.bitangent_y = bitan_c[1];
      f.bitangent_z = bitan_c[2];
      f.vertex_slot = ttb_pkg::SlotW'(k);
      f.last        = (ttb_pkg::SlotW'(k) == ttb_pkg::SlotLast);
      f.degenerate  = degen;
      frames_due.insert(frames_due.size(), f);
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (n_mismatches < MaxReports)
      $display("MISMATCH %s: got %h, expected %h (result word %0d)",
               what, got, want, n_words_checked);
    n_mismatches++;
  endtask

  task automatic check_frame(input ttb_pkg::out_word_t got);
    ttb_pkg::out_word_t want;
    if (frames_due.size() == 0) begin
      flag_mismatch("result word with nothing pending", got.tangent_x, '0);
      return;
    end
    want = frames_due.pop_front();
    if (got.tangent_x !== want.tangent_x)
      flag_mismatch("tangent_x", got.tangent_x, want.tangent_x);
    if (got.tangent_y !== want.tangent_y)
      flag_mismatch("tangent_y", got.tangent_y, want.tangent_y);
    if (got.tangent_z !== want.tangent_z)
      flag_mismatch("tangent_z", got.tangent_z, want.tangent_z);
    if (got.bitangent_x !== want.bitangent_x)
      flag_mismatch("bitangent_x", got.bitangent_x, want.bitangent_x);
    if (got.bitangent_y !== want.bitangent_y)
      flag_mismatch("bitangent_y", got.bitangent_y, want.bitangent_y);
    if (got.bitangent_z !== want.bitangent_z)
      flag_mismatch("bitangent_z", got.bitangent_z, want.bitangent_z);
    if (got.vertex_slot !== want.vertex_slot)
      flag_mismatch("vertex_slot", 32'(got.vertex_slot), 32'(want.vertex_slot));
    if (got.last !== want.last)
      flag_mismatch("last", 32'(got.last), 32'(want.last));
    if (got.degenerate !== want.degenerate)
      flag_mismatch("degenerate", 32'(got.degenerate), 32'(want.degenerate));
    n_words_checked++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) check_frame(out_if.data);
  end

  // watchdog: cycles in which no word moves on either side
  int idle_cycles;
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no word moved for %0d cycles, %0d results pending",
                 IdleLimit, frames_due.size());
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver: switches between open, patterned and sparse acceptance
  initial begin : sink_side
    sink_mode_e mode;
    int mode_left, hold_left, phase;
    logic [7:0] pattern;
    out_if.ready = 1'b0;
    mode = SINK_OPEN;
    mode_left = 0;
    hold_left = 0;
    phase = 0;
    pattern = 8'hFF;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = sink_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(16, 80);
          pattern   = 8'($urandom);
        end
        mode_left--;
        phase = (phase + 1) % 8;
        case (mode)
          SINK_OPEN:    out_if.ready <= 1'b1;
          SINK_PATTERN: out_if.ready <= pattern[phase];
          default:      out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic push_vertex(input ttb_pkg::in_word_t w);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    solve_vertex(w);
  endtask

  task automatic push_triangle(input ttb_pkg::in_word_t a, input ttb_pkg::in_word_t b,
                               input ttb_pkg::in_word_t c);
    push_vertex(a);
    push_vertex(b);
    push_vertex(c);
  endtask

  task automatic send_random_triangle(input tri_kind_e kind);
    int p0[3], p1[3], p2[3];
    int u0, v0, du1, dv1, du2, dv2, k;
    if (kind == TRI_RAW) begin
      push_triangle(make_word($urandom, $urandom, $urandom, $urandom, $urandom),
                    make_word($urandom, $urandom, $urandom, $urandom, $urandom),
                    make_word($urandom, $urandom, $urandom, $urandom, $urandom));
      return;
    end
    for (int i = 0; i < 3; i++) begin
      p0[i] = signed_range(1 << 24);
      p1[i] = p0[i] + signed_range(1 << 18);
      p2[i] = p0[i] + signed_range(1 << 18);
    end
    u0 = signed_range(1 << 22);
    v0 = signed_range(1 << 22);
    case (kind)
      TRI_TINY_UV: begin
        du1 = signed_range(3);
        dv1 = signed_range(3);
        du2 = signed_range(3);
        dv2 = signed_range(3);
      end
      TRI_DEGEN: begin
        // third texcoord on the line through the first two
        k   = signed_range(2);
        du1 = signed_range(1 << 15);
        dv1 = signed_range(1 << 15);
        du2 = k * du1;
        dv2 = k * dv1;
      end
      default: begin
        du1 = signed_range(1 << 15);
        dv1 = signed_range(1 << 15);
        du2 = signed_range(1 << 15);
        dv2 = signed_range(1 << 15);
      end
    endcase
    push_triangle(make_word(p0[0], p0[1], p0[2], u0, v0),
                  make_word(p1[0], p1[1], p1[2], u0 + du1, v0 + dv1),
                  make_word(p2[0], p2[1], p2[2], u0 + du2, v0 + dv2));
  endtask

  task automatic test_basic_orientation();
    push_triangle(make_word(0, 0, 0, 0, 0), make_word(One, 0, 0, One, 0),
                  make_word(0, One, 0, 0, One));
    // swapped texcoords: negative determinant
    push_triangle(make_word(0, 0, 0, 0, 0), make_word(One, 0, 0, 0, One),
                  make_word(0, One, 0, One, 0));
    // determinant of three: quotients truncate toward zero
    push_triangle(make_word(0, 0, 0, 0, 0), make_word(1, -1, 7, 3, 0),
                  make_word(-5, 3, 2, 1, 1));
  endtask

  task automatic test_degenerate_uv();
    push_triangle(make_word(0, 0, 0, One / 2, -One / 2),
                  make_word(One, 2 * One, 0, One / 2, -One / 2),
                  make_word(0, -One, One, One / 2, -One / 2));
    push_triangle(make_word(-1, -1, -1, 0, 0), make_word(-1, -1, -1, One, One),
                  make_word(-1, -1, -1, 2 * One, 2 * One));
  endtask

  task automatic test_saturation();
    push_triangle(make_word(0, 0, 0, 0, 0), make_word(PosMax, PosMin, PosMax, 1, 0),
                  make_word(PosMin, PosMax, PosMin, 0, 1));
    // components land just inside, on and just past the Q16.16 limits
    push_triangle(make_word(0, 0, 0, 0, 0), make_word(32767, -32769, 2, 0, 1),
                  make_word(32768, 1, -32768, 1, 0));
  endtask

  task automatic test_field_extremes();
    push_triangle(make_word(PosMax, PosMin, 0, TexMin, TexMin),
                  make_word(PosMin, PosMax, -1, TexMax, TexMin),
                  make_word(PosMax, PosMax, PosMin, TexMin, TexMax));
  endtask

  task automatic test_random_mesh();
    int r;
    tri_kind_e kind;
    for (int t = 0; t < 54; t++) begin
      gaps_on = (t % 16) < 11;
      r = $urandom_range(0, 99);
      if (r < 65)      kind = TRI_MESH;
      else if (r < 77) kind = TRI_DEGEN;
      else if (r < 90) kind = TRI_TINY_UV;
      else             kind = TRI_RAW;
      send_random_triangle(kind);
    end
    gaps_on = 1'b1;
  endtask

  task automatic test_random_raw();
    for (int t = 0; t < 12; t++) send_random_triangle(TRI_RAW);
  endtask

  task automatic test_backpressure();
    // sink shuts for a long stretch while triangles keep coming
    gaps_on  = 1'b0;
    hold_req = LongHold;
    for (int t = 0; t < 10; t++) send_random_triangle(TRI_MESH);
    gaps_on  = 1'b1;
  endtask

  initial begin : stimulus
    in_if.valid = 1'b0;
    in_if.data  = '0;
    rst_ni      = 1'b0;
    gaps_on     = 1'b1;
    burst_left  = 0;
    hold_req    = 0;
    verts_held  = 0;
    n_vertices = 0; n_triangles = 0; n_degenerate = 0; n_clipped = 0;
    n_words_checked = 0; n_mismatches = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_basic_orientation();
    test_degenerate_uv();
    test_saturation();
    test_field_extremes();
    test_random_mesh();
    test_random_raw();
    test_backpressure();

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("run: %0d vertices in %0d triangles, %0d with zero UV determinant, %0d clipped",
             n_vertices, n_triangles, n_degenerate, n_clipped);
    $display("run: %0d result words checked, %0d mismatches", n_words_checked, n_mismatches);
    if (n_mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/ttb_pkg.sv
rtl/core/ttb_stream_if.sv
rtl/core/triangle_tangent_bitangent.sv
rtl/core/ttb_checker.sv
tb/sv/tb_triangle_tangent_bitangent.sv
